// ----- rtl/biq_pkg.sv -----
// shared types, codes and defaults for the biquad filter
package biq_pkg;

    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_COEF_WIDTH   = 20;
    localparam int DEF_ACC_WIDTH    = 40;

    localparam int NUM_COEFS = 5;
    localparam int COEF_IDX_W = 3;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // register indexes
    localparam logic [COEF_IDX_W-1:0] COEF_C0 = 3'd0;
    localparam logic [COEF_IDX_W-1:0] COEF_C1 = 3'd1;
    localparam logic [COEF_IDX_W-1:0] COEF_C2 = 3'd2;
    localparam logic [COEF_IDX_W-1:0] COEF_D1 = 3'd3;
    localparam logic [COEF_IDX_W-1:0] COEF_D2 = 3'd4;

    // multiplier operand selects
    localparam logic [2:0] MUL_C0_IN = 3'd0;
    localparam logic [2:0] MUL_C1_X  = 3'd1;
    localparam logic [2:0] MUL_D1_Y  = 3'd2;
    localparam logic [2:0] MUL_C2_X  = 3'd3;
    localparam logic [2:0] MUL_D2_Y  = 3'd4;

    // accumulator operations
    localparam logic [1:0] ACC_HOLD    = 2'd0;
    localparam logic [1:0] ACC_S2_PLUS = 2'd1;
    localparam logic [1:0] ACC_SUB     = 2'd2;
    localparam logic [1:0] ACC_LOAD    = 2'd3;

    typedef struct packed {
        logic       x_en;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       y_en;
        logic [1:0] acc_op;
        logic       s1_en;
        logic       s2_en;
    } biq_cmd_t;

endpackage

// ----- rtl/biquad_iir_filter.sv -----
// biquad iir filter top level: apb coefficients, stream in and out
// Second-order IIR section in transposed direct form II. Each sample taken on the
// s_ stream gives one output sample on the m_ stream, rounded half up and
// saturated, with m_tuser set when saturation occurred. One shared multiplier
// forms the five products of a sample in turn, so the block takes a new sample
// only once all five products of the previous one are formed; the c0 product
// is registered and the output then sits in an output register, so processing
// pauses only if the previous output has not been taken when the next one is
// ready. Coefficients are signed Q3.16 at APB byte addresses 0, 4, 8, 12, 16
// (c0, c1, c2, d1, d2); any write to one of them also clears both delay
// accumulators. Write coefficients only while no sample is in flight.
module biquad_iir_filter import biq_pkg::*; #(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH,
    parameter int ACC_WIDTH    = DEF_ACC_WIDTH,
    localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // sample_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // sample_out
    output logic                  m_tuser    // clipped
);

    biq_cmd_t                       cmd;
    logic                           clear_delay;
    logic signed [COEF_WIDTH-1:0]   coef [NUM_COEFS];
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    biq_regs #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .coef        (coef),
        .clear_delay (clear_delay)
    );

    biq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    biq_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .clear_delay (clear_delay),
        .coef        (coef),
        .sample_in   (s_tdata[SAMPLE_WIDTH-1:0]),
        .sample_out  (sample_out),
        .clipped     (m_tuser)
    );

    assign m_tdata = TDATA_W'(unsigned'(sample_out));

endmodule

// ----- rtl/biq_regs.sv -----
// apb coefficient register file
module biq_regs import biq_pkg::*; #(
    parameter int COEF_WIDTH = DEF_COEF_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready,
    output logic signed [COEF_WIDTH-1:0] coef [NUM_COEFS],
    output logic                         clear_delay
);

    localparam int COEF_FRAC = COEF_WIDTH - 4;
    localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
        {{3{1'b0}}, 1'b1, {(COEF_FRAC){1'b0}}};

    logic signed [COEF_WIDTH-1:0] coef_reg [NUM_COEFS];
    logic [COEF_IDX_W-1:0]        idx;
    logic                         wr_en;
    logic                         idx_ok;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign idx_ok = idx < COEF_IDX_W'(NUM_COEFS);
    assign wr_en  = psel & penable & pwrite & idx_ok;
    assign pready = 1'b1;
    assign clear_delay = wr_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEFS; i++) begin
                coef_reg[i] <= (i == int'(COEF_C0)) ? COEF_ONE : '0;
            end
        end else if (wr_en) begin
            coef_reg[idx] <= pwdata[COEF_WIDTH-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (idx_ok) begin
            prdata = APB_DATA_W'(unsigned'(coef_reg[idx]));
        end
    end

    assign coef = coef_reg;

endmodule

// ----- rtl/biq_ctrl.sv -----
// sequencer for the shared multiplier and output handshake
module biq_ctrl import biq_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output biq_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_Y    = 3'd1;
    localparam logic [2:0] ST_C1   = 3'd2;
    localparam logic [2:0] ST_D1   = 3'd3;
    localparam logic [2:0] ST_C2   = 3'd4;
    localparam logic [2:0] ST_D2   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_vld_reg, out_vld_next;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE) || (state_reg == ST_D2);
    assign out_free = !out_vld_reg || m_tready;
    assign m_tvalid = out_vld_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.x_en    = 1'b1;
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_C0_IN;
                    state_next  = ST_Y;
                end
            end
            ST_Y: begin
                // hold until the output register can take the new sample
                if (out_free) begin
                    cmd.y_en    = 1'b1;
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_C1_X;
                    state_next  = ST_C1;
                end
            end
            ST_C1: begin
                cmd.acc_op  = ACC_S2_PLUS;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_D1_Y;
                state_next  = ST_D1;
            end
            ST_D1: begin
                cmd.acc_op  = ACC_SUB;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_C2_X;
                state_next  = ST_C2;
            end
            ST_C2: begin
                cmd.s1_en   = 1'b1;
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_D2_Y;
                state_next  = ST_D2;
            end
            ST_D2: begin
                cmd.s2_en = 1'b1;
                if (s_tvalid) begin
                    cmd.x_en    = 1'b1;
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_C0_IN;
                    state_next  = ST_Y;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (cmd.y_en) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

endmodule

// ----- rtl/biq_dp.sv -----
// datapath: shared multiplier, accumulator and delay registers
module biq_dp import biq_pkg::*; #(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH,
    parameter int ACC_WIDTH    = DEF_ACC_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  biq_cmd_t                       cmd,
    input  logic                           clear_delay,
    input  logic signed [COEF_WIDTH-1:0]   coef [NUM_COEFS],
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           clipped
);

    localparam int COEF_FRAC = COEF_WIDTH - 4;
    localparam int PROD_W    = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int SUM_W     = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 2;

    localparam logic signed [SUM_W-1:0] ACC_MAX =
        {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;
    localparam logic signed [SUM_W-1:0] SMP_MAX =
        {{(SUM_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SMP_MIN = ~SMP_MAX;
    localparam logic signed [SUM_W-1:0] HALF_LSB =
        {{(SUM_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic                           clip_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [SUM_W-1:0]        acc_reg;
    logic signed [ACC_WIDTH-1:0]    s1_reg;
    logic signed [ACC_WIDTH-1:0]    s2_reg;

    logic signed [COEF_WIDTH-1:0]   mul_a;
    logic signed [SAMPLE_WIDTH-1:0] mul_b;
    logic signed [PROD_W-1:0]       prod_c;
    logic signed [SUM_W-1:0]        prod_ext;
    logic signed [SUM_W-1:0]        diff;
    logic signed [SUM_W-1:0]        y_sum;
    logic signed [SUM_W-1:0]        y_shift;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;
    logic                           y_clip;
    logic signed [ACC_WIDTH-1:0]    s1_sat;
    logic signed [ACC_WIDTH-1:0]    s2_sat;

    always_comb begin
        mul_a = coef[COEF_C0];
        mul_b = sample_in;
        case (cmd.mul_sel)
            MUL_C0_IN: begin mul_a = coef[COEF_C0]; mul_b = sample_in; end
            MUL_C1_X:  begin mul_a = coef[COEF_C1]; mul_b = x_reg;     end
            MUL_D1_Y:  begin mul_a = coef[COEF_D1]; mul_b = y_reg;     end
            MUL_C2_X:  begin mul_a = coef[COEF_C2]; mul_b = x_reg;     end
            MUL_D2_Y:  begin mul_a = coef[COEF_D2]; mul_b = y_reg;     end
            default:   begin mul_a = coef[COEF_C0]; mul_b = sample_in; end
        endcase
    end

    assign prod_c   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_ext = SUM_W'(prod_reg);
    assign diff     = acc_reg - prod_ext;

    // output: round half up, then clamp to the sample range
    assign y_sum   = prod_ext + SUM_W'(s1_reg) + HALF_LSB;
    assign y_shift = y_sum >>> COEF_FRAC;

    always_comb begin
        y_clip = 1'b0;
        y_sat  = y_shift[SAMPLE_WIDTH-1:0];
        if (y_shift > SMP_MAX) begin
            y_clip = 1'b1;
            y_sat  = SMP_MAX[SAMPLE_WIDTH-1:0];
        end else if (y_shift < SMP_MIN) begin
            y_clip = 1'b1;
            y_sat  = SMP_MIN[SAMPLE_WIDTH-1:0];
        end
    end

    always_comb begin
        s1_sat = acc_reg[ACC_WIDTH-1:0];
        if (acc_reg > ACC_MAX) begin
            s1_sat = ACC_MAX[ACC_WIDTH-1:0];
        end else if (acc_reg < ACC_MIN) begin
            s1_sat = ACC_MIN[ACC_WIDTH-1:0];
        end
        s2_sat = diff[ACC_WIDTH-1:0];
        if (diff > ACC_MAX) begin
            s2_sat = ACC_MAX[ACC_WIDTH-1:0];
        end else if (diff < ACC_MIN) begin
            s2_sat = ACC_MIN[ACC_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.x_en) begin
            x_reg <= sample_in;
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_c;
        end
        if (cmd.y_en) begin
            y_reg    <= y_sat;
            clip_reg <= y_clip;
        end
        case (cmd.acc_op)
            ACC_S2_PLUS: acc_reg <= SUM_W'(s2_reg) + prod_ext;
            ACC_SUB:     acc_reg <= diff;
            ACC_LOAD:    acc_reg <= prod_ext;
            default:     acc_reg <= acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear_delay) begin
            s1_reg <= '0;
            s2_reg <= '0;
        end else begin
            if (cmd.s1_en) begin
                s1_reg <= s1_sat;
            end
            if (cmd.s2_en) begin
                s2_reg <= s2_sat;
            end
        end
    end

    assign sample_out = y_reg;
    assign clipped    = clip_reg;

endmodule
